/* rtl/core/rrf_pkg.sv */
// rrf_pkg: shared types and constants of the rectangle rasterizer
// used by rrf_front, rrf_fifo, rrf_back and rectangle_raster_fill_outline
package rrf_pkg;

    // fixed field widths
    localparam int COORD_W    = 20;
    localparam int CHAR_W     = 8;
    localparam int PIX_W      = 9;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int OPCODE_W   = 2;
    localparam int IN_USER_W  = OPCODE_W + 1;
    localparam int IN_DATA_W  = 4 * COORD_W + CHAR_W + 2 * PIX_W;
    localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;

    // command opcodes
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 2'd2;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0]  CANVAS_SIDE_RST = 10'd1;
    localparam logic [CHAR_W-1:0] BACKGROUND_RST  = 8'd32;

    // command class decided by the front end
    typedef enum logic [2:0] {
        K_NOP,
        K_CLEAR,
        K_DRAW,
        K_REJECT,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic                      filled;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic signed [COORD_W-1:0] rect_w;
        logic signed [COORD_W-1:0] rect_h;
        logic [CHAR_W-1:0]         fill_char;
        logic [PIX_W-1:0]          pixel_row;
        logic [PIX_W-1:0]          pixel_col;
    } t_cmd;

endpackage

/* rtl/core/rrf_front.sv */
// rrf_front: unpacks an input request and classifies it into a command
// depends on rrf_pkg
module rrf_front import rrf_pkg::*; (
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [IN_DATA_W-1:0] i_tdata,
    input  logic [IN_USER_W-1:0] i_tuser,
    input  logic                 i_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [OPCODE_W-1:0] opcode;
    logic                size_bad;

    assign opcode   = i_tuser[OPCODE_W-1:0];
    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    // nonpositive width or height
    assign size_bad = i_tdata[3*COORD_W-1] || (i_tdata[2*COORD_W +: COORD_W] == '0) ||
                      i_tdata[4*COORD_W-1] || (i_tdata[3*COORD_W +: COORD_W] == '0);

    always_comb begin
        o_cmd.filled    = i_tuser[OPCODE_W];
        o_cmd.rect_x    = i_tdata[0*COORD_W +: COORD_W];
        o_cmd.rect_y    = i_tdata[1*COORD_W +: COORD_W];
        o_cmd.rect_w    = i_tdata[2*COORD_W +: COORD_W];
        o_cmd.rect_h    = i_tdata[3*COORD_W +: COORD_W];
        o_cmd.fill_char = i_tdata[4*COORD_W +: CHAR_W];
        o_cmd.pixel_row = i_tdata[4*COORD_W+CHAR_W +: PIX_W];
        o_cmd.pixel_col = i_tdata[4*COORD_W+CHAR_W+PIX_W +: PIX_W];
        unique case (opcode)
            OP_CLEAR: o_cmd.kind = K_CLEAR;
            OP_DRAW:  o_cmd.kind = size_bad ? K_REJECT : K_DRAW;
            OP_READ:  o_cmd.kind = K_READ;
            default:  o_cmd.kind = K_NOP;
        endcase
    end

endmodule

/* rtl/core/rrf_fifo.sv */
// rrf_fifo: two-entry command queue between front end and back end
// depends on rrf_pkg
module rrf_fifo import rrf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_entry[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/rrf_back.sv */
// rrf_back: frame store, pixel sweep sequencer and result register
// depends on rrf_pkg; fed by rrf_fifo
module rrf_back import rrf_pkg::*; #(
    parameter  int MAX_SIDE  = 512,
    parameter  int FRAC_BITS = 8,
    localparam int SW        = $clog2(MAX_SIDE)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SW:0]       i_canvas_w,
    input  logic [SW:0]       i_canvas_h,
    input  logic [CHAR_W-1:0] i_background,
    input  logic              i_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic              o_status,
    output logic [CHAR_W-1:0] o_pixel_char
);

    localparam int AW    = 2 * SW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = ((SW + FRAC_BITS > COORD_W + 1) ? SW + FRAC_BITS : COORD_W + 1) + 2;
    localparam int RW    = ((SW > PIX_W) ? SW : PIX_W) + 1;
    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_READ,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [SW-1:0]         r_x;
    logic [SW-1:0]         r_y;
    logic                  r_is_draw;
    logic                  r_is_read;
    logic                  r_filled;
    logic                  r_status;
    logic [CHAR_W-1:0]     r_char;
    logic signed [CW-1:0]  r_x0;
    logic signed [CW-1:0]  r_x1;
    logic signed [CW-1:0]  r_xi0;
    logic signed [CW-1:0]  r_xi1;
    logic signed [CW-1:0]  r_y0;
    logic signed [CW-1:0]  r_y1;
    logic signed [CW-1:0]  r_yi0;
    logic signed [CW-1:0]  r_yi1;
    logic                  r_rd_ok;
    logic [AW-1:0]         r_rd_addr;
    logic [CHAR_W-1:0]     r_rd_data;
    logic [CHAR_W-1:0]     r_mem [DEPTH];
    logic                  r_out_valid;
    logic                  r_out_status;
    logic [CHAR_W-1:0]     r_out_pix;

    logic signed [CW-1:0]  rx;
    logic signed [CW-1:0]  ry;
    logic signed [CW-1:0]  rx_end;
    logic signed [CW-1:0]  ry_end;
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
    logic                  in_rect;
    logic                  near_edge;
    logic                  w_en;
    logic [AW-1:0]         w_addr;
    logic                  x_last;
    logic                  y_last;
    logic                  canvas_empty;
    logic                  out_free;
    logic [RW-1:0]         row_ext;
    logic [RW-1:0]         col_ext;

    // rectangle bounds in pixel fixed point
    assign rx     = CW'(i_cmd.rect_x);
    assign ry     = CW'(i_cmd.rect_y);
    assign rx_end = rx + CW'(i_cmd.rect_w);
    assign ry_end = ry + CW'(i_cmd.rect_h);

    assign px = signed'(CW'(r_x) << FRAC_BITS);
    assign py = signed'(CW'(r_y) << FRAC_BITS);

    assign in_rect   = (px >= r_x0) && (px <= r_x1) && (py >= r_y0) && (py <= r_y1);
    assign near_edge = (px < r_xi0) || (px > r_xi1) || (py < r_yi0) || (py > r_yi1);

    assign w_en   = (r_state == S_SWEEP) &&
                    (!r_is_draw || (in_rect && (r_filled || near_edge)));
    assign w_addr = {r_y, r_x};

    assign x_last       = ({1'b0, r_x} == i_canvas_w - (SW+1)'(1));
    assign y_last       = ({1'b0, r_y} == i_canvas_h - (SW+1)'(1));
    assign canvas_empty = (i_canvas_w == '0) || (i_canvas_h == '0);

    assign row_ext = RW'(i_cmd.pixel_row);
    assign col_ext = RW'(i_cmd.pixel_col);

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_free = !r_out_valid || i_tready;

    assign o_tvalid     = r_out_valid;
    assign o_status     = r_out_status;
    assign o_pixel_char = r_out_pix;

    // frame store: one write port for the sweep, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= r_char;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_x       <= '0;
                        r_y       <= '0;
                        r_status  <= 1'b0;
                        r_is_read <= 1'b0;
                        r_is_draw <= (i_cmd.kind == K_DRAW);
                        r_filled  <= i_cmd.filled;
                        r_char    <= (i_cmd.kind == K_DRAW) ? i_cmd.fill_char : i_background;
                        r_x0      <= rx;
                        r_x1      <= rx_end;
                        r_xi0     <= rx + signed'(ONE);
                        r_xi1     <= rx_end - signed'(ONE);
                        r_y0      <= ry;
                        r_y1      <= ry_end;
                        r_yi0     <= ry + signed'(ONE);
                        r_yi1     <= ry_end - signed'(ONE);
                        r_rd_ok   <= (row_ext < RW'(MAX_SIDE)) && (col_ext < RW'(MAX_SIDE));
                        r_rd_addr <= {row_ext[SW-1:0], col_ext[SW-1:0]};
                        unique case (i_cmd.kind)
                            K_CLEAR, K_DRAW: begin
                                r_state <= canvas_empty ? S_DONE : S_SWEEP;
                            end
                            K_REJECT: begin
                                r_status <= 1'b1;
                                r_state  <= S_DONE;
                            end
                            K_READ: begin
                                r_is_read <= 1'b1;
                                r_state   <= S_READ;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    if (x_last) begin
                        r_x <= '0;
                        if (y_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_y <= r_y + SW'(1);
                        end
                    end else begin
                        r_x <= r_x + SW'(1);
                    end
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_pix    <= (r_is_read && r_rd_ok) ? r_rd_data : '0;
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // sweep stays inside the active canvas
    a_sweep_in_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (({1'b0, r_x} < i_canvas_w) && ({1'b0, r_y} < i_canvas_h)))
        else $error("sweep counter left the canvas");

    // a rejected draw never reaches the sweep
    a_reject_no_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !r_status)
        else $error("rejected draw is sweeping");

    // a read command goes through the memory read cycle
    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_cmd.kind == K_READ)) |=> (r_state == S_READ))
        else $error("read command skipped the memory read");

    // a result appears only out of the done state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

endmodule

/* rtl/core/rectangle_raster_fill_outline.sv */
// rectangle_raster_fill_outline: top level of the character frame store rasterizer
// depends on rrf_pkg, rrf_front, rrf_fifo, rrf_back
//
// Byte frame store with clear, rectangle draw and pixel read commands. Each
// request on the slave stream carries one command and gives exactly one result
// on the master stream (status 1 for a draw with nonpositive width or height,
// pixel_char for a read, zero otherwise). The front end classifies requests
// into a two-entry queue so new requests are taken while the back end works
// and while a result waits on the master side. Clear and draw visit each
// pixel of the active canvas in turn, one per cycle, as the frame store has a
// single write port; a read passes through a memory read state, a rejected
// draw or unused opcode goes to done. Rectangle corner and size are signed fixed
// point with FRAC_BITS fraction bits. The frame store is not cleared at reset;
// reading a pixel that was never written returns an undefined byte. Canvas
// size registers above MAX_SIDE act as MAX_SIDE, zero gives an empty canvas.
// Configuration writes are always ready and should only be issued while idle.
module rectangle_raster_fill_outline import rrf_pkg::*; #(
    parameter int MAX_SIDE  = 512,
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // rect_x[19:0] rect_y[39:20] rect_w[59:40] rect_h[79:60] fill_char[87:80]
    // pixel_row[96:88] pixel_col[105:97], zero padding above
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // opcode[1:0] filled[2]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_char[7:0]
    output logic [CHAR_W-1:0]     m_axis_tdata,
    // status[0]
    output logic [0:0]            m_axis_tuser,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int SW = $clog2(MAX_SIDE);
    localparam int LW = (SW + 1 > CFG_W) ? SW + 1 : CFG_W;

    logic [CFG_W-1:0]  r_canvas_width;
    logic [CFG_W-1:0]  r_canvas_height;
    logic [CHAR_W-1:0] r_background;

    logic [LW-1:0]     w_ext;
    logic [LW-1:0]     h_ext;
    logic [LW-1:0]     w_sat;
    logic [LW-1:0]     h_sat;

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    t_cmd              front_cmd;
    t_cmd              q_cmd;

    // config writes are always accepted and are registered directly
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= CANVAS_SIDE_RST;
            r_canvas_height <= CANVAS_SIDE_RST;
            r_background    <= BACKGROUND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg_data;
                REG_CANVAS_HEIGHT: r_canvas_height <= i_cfg_data;
                REG_BACKGROUND:    r_background    <= i_cfg_data[CHAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // active canvas size saturates at the store side
    assign w_ext = LW'(r_canvas_width);
    assign h_ext = LW'(r_canvas_height);
    assign w_sat = (w_ext > LW'(MAX_SIDE)) ? LW'(MAX_SIDE) : w_ext;
    assign h_sat = (h_ext > LW'(MAX_SIDE)) ? LW'(MAX_SIDE) : h_ext;

    // front end: unpack and classify
    rrf_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata[IN_DATA_W-1:0]),
        .i_tuser  (s_axis_tuser),
        .i_full   (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    // command queue decoupling front and back
    rrf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    // back end: frame store sweep and result register
    rrf_back #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_canvas_w   (w_sat[SW:0]),
        .i_canvas_h   (h_sat[SW:0]),
        .i_background (r_background),
        .i_empty      (q_empty),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_status     (m_axis_tuser[0]),
        .o_pixel_char (m_axis_tdata)
    );

endmodule
